@@ hdl/wall_range_odometry_localizer_top_assert.svh @@
// Assertion macros shared by the localizer modules.
// Each use expects clk and arst_n in scope.
`ifndef WALL_RANGE_ODOMETRY_LOCALIZER_TOP_ASSERT_SVH
`define WALL_RANGE_ODOMETRY_LOCALIZER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define WRL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("wrl assertion failed");
`define WRL_NEVER(lbl, expr) \
	`WRL_ASSERT(lbl, !(expr))
`else
`define WRL_ASSERT(lbl, prop)
`define WRL_NEVER(lbl, expr)
`endif

`endif

@@ hdl/wrl_pkg.sv @@
`default_nettype none
package wrl_pkg;

	localparam int RING_DEPTH = 5;
	localparam int RING_IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int RING_CNT_W = $clog2(RING_DEPTH + 1);

	localparam int LEN_W = 19;
	localparam int POS_W = 20;
	localparam int HDG_W = 9;
	localparam int TOL_W = 16;
	localparam int COS_W = 17;
	localparam int SAT_W = 24;
	localparam int PROD_W = 38;
	localparam int NUM_W = 39;
	localparam int SUM_W = POS_W + $clog2(RING_DEPTH) + 1;
	localparam int SPAN_W = 24;

	localparam int DIV_N_W = 36;
	localparam int DIV_Q_W = 22;
	localparam int DIV_D_W = 17;
	localparam int DIV_CNT_W = 5;

	// ring average by reciprocal multiplication of the biased, non-negative sum
	localparam int AVG_SHIFT = 32;
	localparam int AVG_M_W = 32;
	localparam int AVG_PROD_W = SUM_W + AVG_M_W;
	localparam logic [AVG_M_W-1:0] AVG_RECIP =
		AVG_M_W'(((64'd1 << AVG_SHIFT) + 64'(RING_DEPTH - 1)) / 64'(RING_DEPTH));
	localparam logic [SUM_W-1:0] AVG_BIAS = SUM_W'(RING_DEPTH * (2**POS_W) + RING_DEPTH / 2);

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [2:0] CMD_LEFT = 3'd0;
	localparam logic [2:0] CMD_RIGHT = 3'd1;
	localparam logic [2:0] CMD_ODOM = 3'd2;
	localparam logic [2:0] CMD_HEAD = 3'd3;
	localparam logic [2:0] CMD_MOTOR = 3'd4;

	localparam logic [2:0] REG_COURSE = 3'd0;
	localparam logic [2:0] REG_ROBOT_W = 3'd1;
	localparam logic [2:0] REG_TOL = 3'd2;
	localparam logic [2:0] REG_START_X = 3'd3;
	localparam logic [2:0] REG_START_Y = 3'd4;
	localparam logic [2:0] REG_START_HDG = 3'd5;

	localparam logic [LEN_W-1:0] RST_COURSE = 19'd121242;
	localparam logic [TOL_W-1:0] RST_ROBOT_W = 16'd11653;
	localparam logic [TOL_W-1:0] RST_TOL = 16'd3277;
	localparam logic signed [POS_W-1:0] RST_START_X = 20'sd68813;
	localparam logic signed [POS_W-1:0] RST_START_Y = 20'sd9830;
	localparam logic [HDG_W-1:0] RST_START_HDG = 9'd90;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV_EXP,
		S_WAIT_EXP,
		S_SIDE,
		S_UPD,
		S_SUM,
		S_DIV_AVG,
		S_APPLY,
		S_OUT
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic div_exp;
		logic side_wr;
		logic sum_clr;
		logic sum_step;
		logic div_avg;
		logic apply;
		logic use_avg;
		logic load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic turn;
		logic full;
		logic div_busy;
		logic sum_last;
	} dp_status_t;

	typedef struct packed {
		logic [LEN_W-1:0] course_size;
		logic [TOL_W-1:0] body_width;
		logic [TOL_W-1:0] tolerance;
	} cfg_t;

	typedef struct packed {
		logic x_we;
		logic y_we;
		logic hdg_we;
		logic signed [POS_W-1:0] start_x;
		logic signed [POS_W-1:0] start_y;
		logic [HDG_W-1:0] start_heading;
	} cfg_wr_t;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = SAT_W'(2**(POS_W-1) - 1);
		lo = -SAT_W'(2**(POS_W-1));
		if (v > hi) begin
			return POS_W'(hi);
		end else if (v < lo) begin
			return POS_W'(lo);
		end
		return v[POS_W-1:0];
	endfunction

	// Q16 cosine of whole degrees 0..45
	function automatic logic [COS_W-1:0] cos_q16(input logic [5:0] deg);
		case (deg)
			6'd0: return 17'd65536;
			6'd1: return 17'd65526;
			6'd2: return 17'd65496;
			6'd3: return 17'd65446;
			6'd4: return 17'd65376;
			6'd5: return 17'd65287;
			6'd6: return 17'd65177;
			6'd7: return 17'd65048;
			6'd8: return 17'd64898;
			6'd9: return 17'd64729;
			6'd10: return 17'd64540;
			6'd11: return 17'd64332;
			6'd12: return 17'd64104;
			6'd13: return 17'd63856;
			6'd14: return 17'd63589;
			6'd15: return 17'd63303;
			6'd16: return 17'd62997;
			6'd17: return 17'd62672;
			6'd18: return 17'd62328;
			6'd19: return 17'd61966;
			6'd20: return 17'd61584;
			6'd21: return 17'd61183;
			6'd22: return 17'd60764;
			6'd23: return 17'd60326;
			6'd24: return 17'd59870;
			6'd25: return 17'd59396;
			6'd26: return 17'd58903;
			6'd27: return 17'd58393;
			6'd28: return 17'd57865;
			6'd29: return 17'd57319;
			6'd30: return 17'd56756;
			6'd31: return 17'd56175;
			6'd32: return 17'd55578;
			6'd33: return 17'd54963;
			6'd34: return 17'd54332;
			6'd35: return 17'd53684;
			6'd36: return 17'd53020;
			6'd37: return 17'd52339;
			6'd38: return 17'd51643;
			6'd39: return 17'd50931;
			6'd40: return 17'd50203;
			6'd41: return 17'd49461;
			6'd42: return 17'd48703;
			6'd43: return 17'd47930;
			6'd44: return 17'd47143;
			default: return 17'd46341;
		endcase
	endfunction

endpackage
`default_nettype wire

@@ hdl/wall_range_odometry_localizer_top.sv @@
// Channel   Direction  Handshake               Payload
// config    in/out     psel/penable/pready     paddr, pwdata, prdata (six registers at 4*i)
// input     in         in_valid / in_stall     cmd, range_value, odom_x, odom_y, heading_in,
//                                              motor_turn
// output    out        out_valid / out_stall   pos_x, pos_y, heading_out, is_turning
//
// One item at a time. Motor commands, ignored codes and events dropped while turning
// are taken in idle and give no result. Odometry and heading go to the update, first
// through a ring sum and one reciprocal multiply for the average once the side ring is
// full. Range events first run the 22-step serial divider for the expected wall span and
// write the side ring, then take the same path. Reset loads the start pose.
// A result waits in the output register under out_stall while the next item is taken;
// each further stalled cycle holds that next item in its last state.
`default_nettype none
module wall_range_odometry_localizer_top import wrl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_stall,
	input  logic [2:0] cmd,
	input  logic [LEN_W-1:0] range_value,
	input  logic signed [POS_W-1:0] odom_x,
	input  logic signed [POS_W-1:0] odom_y,
	input  logic signed [HDG_W-1:0] heading_in,
	input  logic motor_turn,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic [HDG_W-1:0] heading_out,
	output logic is_turning
);

	logic [LEN_W-1:0] course_q;
	logic [TOL_W-1:0] robot_w_q;
	logic [TOL_W-1:0] tol_q;
	logic signed [POS_W-1:0] start_x_q;
	logic signed [POS_W-1:0] start_y_q;
	logic [HDG_W-1:0] start_hdg_q;

	logic wr_en;
	logic [2:0] reg_idx;
	cfg_t cfg;
	cfg_wr_t cfg_wr;
	ctl_cmd_t ctl;
	dp_status_t st;
	logic out_free;

	logic signed [POS_W-1:0] est_x, est_y;
	logic [HDG_W-1:0] heading;
	logic turn;

	logic out_valid_q;
	logic signed [POS_W-1:0] pos_x_q, pos_y_q;
	logic [HDG_W-1:0] hdg_out_q;
	logic turn_out_q;

	// register file: a transfer completes in the access phase, no wait states
	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			course_q <= RST_COURSE;
			robot_w_q <= RST_ROBOT_W;
			tol_q <= RST_TOL;
			start_x_q <= RST_START_X;
			start_y_q <= RST_START_Y;
			start_hdg_q <= RST_START_HDG;
		end else if (wr_en) begin
			case (reg_idx)
				REG_COURSE: course_q <= pwdata[LEN_W-1:0];
				REG_ROBOT_W: robot_w_q <= pwdata[TOL_W-1:0];
				REG_TOL: tol_q <= pwdata[TOL_W-1:0];
				REG_START_X: start_x_q <= pwdata[POS_W-1:0];
				REG_START_Y: start_y_q <= pwdata[POS_W-1:0];
				REG_START_HDG: start_hdg_q <= pwdata[HDG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_COURSE: prdata = PDATA_W'(course_q);
			REG_ROBOT_W: prdata = PDATA_W'(robot_w_q);
			REG_TOL: prdata = PDATA_W'(tol_q);
			REG_START_X: prdata = PDATA_W'(start_x_q);
			REG_START_Y: prdata = PDATA_W'(start_y_q);
			REG_START_HDG: prdata = PDATA_W'(start_hdg_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.course_size = course_q;
	assign cfg.body_width = robot_w_q;
	assign cfg.tolerance = tol_q;

	// start pose writes also reload the pose state in the datapath
	assign cfg_wr.x_we = wr_en && (reg_idx == REG_START_X);
	assign cfg_wr.y_we = wr_en && (reg_idx == REG_START_Y);
	assign cfg_wr.hdg_we = wr_en && (reg_idx == REG_START_HDG);
	assign cfg_wr.start_x = pwdata[POS_W-1:0];
	assign cfg_wr.start_y = pwdata[POS_W-1:0];
	assign cfg_wr.start_heading = pwdata[HDG_W-1:0];

	// the result slot can take a new result when empty or being drained this cycle
	assign out_free = ~out_valid_q | ~out_stall;

	wrl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.cmd(cmd),
		.st(st),
		.out_free(out_free),
		.in_stall(in_stall),
		.ctl(ctl)
	);

	wrl_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.cfg(cfg),
		.cfg_wr(cfg_wr),
		.cmd(cmd),
		.range_value(range_value),
		.odom_x(odom_x),
		.odom_y(odom_y),
		.heading_in(heading_in),
		.motor_turn(motor_turn),
		.st(st),
		.est_x(est_x),
		.est_y(est_y),
		.heading(heading),
		.turn(turn)
	);

	// output register: hold the result under stall, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			pos_x_q <= est_x;
			pos_y_q <= est_y;
			hdg_out_q <= heading;
			turn_out_q <= turn;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign heading_out = hdg_out_q;
	assign is_turning = turn_out_q;

endmodule
`default_nettype wire

@@ hdl/wrl_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit a cycle; quotient known to fit DIV_Q_W bits
module wrl_div import wrl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [DIV_N_W-1:0] dividend,
	input  logic [DIV_D_W-1:0] divisor,
	output logic busy,
	output logic [DIV_Q_W-1:0] quotient
);

	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] den_q;
	logic [DIV_Q_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic [DIV_D_W:0] trial;
	logic [DIV_D_W:0] diff;
	logic ge;

	assign trial = {rem_q, quo_q[DIV_Q_W-1]};
	assign diff = trial - {1'b0, den_q};
	assign ge = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= DIV_CNT_W'(DIV_Q_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {{(DIV_D_W-(DIV_N_W-DIV_Q_W)){1'b0}}, dividend[DIV_N_W-1:DIV_Q_W]};
			quo_q <= dividend[DIV_Q_W-1:0];
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			quo_q <= {quo_q[DIV_Q_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

@@ hdl/wrl_ctrl.sv @@
`default_nettype none
`include "wall_range_odometry_localizer_top_assert.svh"
module wrl_ctrl import wrl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [2:0] cmd,
	input  dp_status_t st,
	input  logic out_free,
	output logic in_stall,
	output ctl_cmd_t ctl
);

	ctl_state_t state_q;
	ctl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		ctl = '0;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.accept = 1'b1;
					if (cmd inside {CMD_LEFT, CMD_RIGHT}) begin
						if (!st.turn) state_nxt = S_DIV_EXP;
					end else if (cmd == CMD_ODOM) begin
						if (!st.turn) state_nxt = S_UPD;
					end else if (cmd == CMD_HEAD) begin
						state_nxt = S_UPD;
					end
				end
			end
			S_DIV_EXP: begin
				ctl.div_exp = 1'b1;
				state_nxt = S_WAIT_EXP;
			end
			S_WAIT_EXP: begin
				if (!st.div_busy) state_nxt = S_SIDE;
			end
			S_SIDE: begin
				ctl.side_wr = 1'b1;
				state_nxt = S_UPD;
			end
			S_UPD: begin
				if (st.turn) begin
					state_nxt = S_OUT;
				end else if (st.full) begin
					ctl.sum_clr = 1'b1;
					state_nxt = S_SUM;
				end else begin
					ctl.apply = 1'b1;
					state_nxt = S_OUT;
				end
			end
			S_SUM: begin
				ctl.sum_step = 1'b1;
				if (st.sum_last) state_nxt = S_DIV_AVG;
			end
			S_DIV_AVG: begin
				ctl.div_avg = 1'b1;
				state_nxt = S_APPLY;
			end
			S_APPLY: begin
				ctl.apply = 1'b1;
				ctl.use_avg = 1'b1;
				state_nxt = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	`WRL_ASSERT(a_div_free, ctl.div_exp |-> !st.div_busy)
	`WRL_ASSERT(a_out_room, ctl.load_out |-> out_free)
	`WRL_ASSERT(a_avg_full, (ctl.apply && ctl.use_avg) |-> st.full)

endmodule
`default_nettype wire

@@ hdl/wrl_dp.sv @@
`default_nettype none
`include "wall_range_odometry_localizer_top_assert.svh"
module wrl_dp import wrl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  ctl_cmd_t ctl,
	input  cfg_t cfg,
	input  cfg_wr_t cfg_wr,
	input  logic [2:0] cmd,
	input  logic [LEN_W-1:0] range_value,
	input  logic signed [POS_W-1:0] odom_x,
	input  logic signed [POS_W-1:0] odom_y,
	input  logic signed [HDG_W-1:0] heading_in,
	input  logic motor_turn,
	output dp_status_t st,
	output logic signed [POS_W-1:0] est_x,
	output logic signed [POS_W-1:0] est_y,
	output logic [HDG_W-1:0] heading,
	output logic turn
);

	logic signed [POS_W-1:0] est_x_q, est_y_q, odo_x_q, odo_y_q, odo_px_q, odo_py_q;
	logic [LEN_W-1:0] left_q, right_q;
	logic signed [POS_W-1:0] ring_q [RING_DEPTH];
	logic [RING_IDX_W-1:0] ring_idx_q;
	logic [RING_CNT_W-1:0] ring_fill_q;
	logic [HDG_W-1:0] heading_q;
	logic turn_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [SUM_W-1:0] sum_q;
	logic [RING_IDX_W-1:0] sum_idx_q;
	logic signed [POS_W-1:0] avg_q;

	logic signed [9:0] h_s, off;
	logic [9:0] off_abs;
	logic [5:0] off_deg;
	logic form_a, facing_y;
	logic [COS_W-1:0] cos_v;
	logic signed [POS_W-1:0] lr_diff;
	logic signed [NUM_W-1:0] cs_ext, prod_ext, num, num_r;
	logic signed [POS_W-1:0] entry;
	logic [POS_W-1:0] lr_sum;
	logic signed [SPAN_W-1:0] expect_v, span;
	logic [SPAN_W-1:0] span_abs;
	logic span_ok;
	logic div_start, div_busy;
	logic [DIV_N_W-1:0] div_num;
	logic [DIV_D_W-1:0] div_den;
	logic [DIV_Q_W-1:0] quo;
	logic [AVG_PROD_W-1:0] avg_prod;
	logic signed [POS_W-1:0] avg;
	logic any_dev, avg_ok;
	logic signed [SAT_W-1:0] step_x, step_y;
	logic [HDG_W-1:0] hdg_wrapped;

	// heading sector, offset from nearest axis and which sign the lateral estimate takes
	always_comb begin
		h_s = $signed({1'b0, heading_q});
		if (heading_q > 9'd45 && heading_q <= 9'd135) begin
			off = 10'sd90 - h_s;
			form_a = 1'b1;
		end else if (heading_q > 9'd135 && heading_q <= 9'd225) begin
			off = h_s - 10'sd180;
			form_a = 1'b1;
		end else if (heading_q > 9'd225 && heading_q <= 9'd315) begin
			off = 10'sd270 - h_s;
			form_a = 1'b0;
		end else begin
			off = (heading_q > 9'd315) ? h_s - 10'sd360 : h_s;
			form_a = 1'b0;
		end
		off_abs = off[9] ? 10'(-off) : 10'(off);
		off_deg = (off_abs > 10'd45) ? 6'd45 : off_abs[5:0];
		facing_y = (heading_q > 9'd45 && heading_q <= 9'd135) ||
			(heading_q > 9'd225 && heading_q <= 9'd315);
	end

	assign cos_v = cos_q16(off_deg);
	assign lr_diff = $signed({1'b0, left_q}) - $signed({1'b0, right_q});

	// lateral entry = floor((C*2^16 +/- (L-R)*c + 2^16) / 2^17), saturated
	assign cs_ext = $signed({4'b0, cfg.course_size, 16'b0});
	assign prod_ext = {{(NUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign num = form_a ? cs_ext + prod_ext : cs_ext - prod_ext;
	assign num_r = num + NUM_W'(65536);
	assign entry = sat_pos(SAT_W'($signed(num_r[NUM_W-1:17])));

	// span check against the rounded course_size/cos less robot width
	assign lr_sum = {1'b0, left_q} + {1'b0, right_q};
	assign expect_v = $signed({{(SPAN_W-DIV_Q_W){1'b0}}, quo}) -
		$signed({{(SPAN_W-TOL_W){1'b0}}, cfg.body_width});
	assign span = expect_v - $signed({{(SPAN_W-POS_W){1'b0}}, lr_sum});
	assign span_abs = span[SPAN_W-1] ? SPAN_W'(-span) : SPAN_W'(span);
	assign span_ok = span_abs < {{(SPAN_W-TOL_W-1){1'b0}}, cfg.tolerance, 1'b0};

	// serial divider for the expected span, rounded to nearest
	assign div_start = ctl.div_exp;
	assign div_num = DIV_N_W'({cfg.course_size, 16'b0}) + DIV_N_W'(cos_v[COS_W-1:1]);
	assign div_den = cos_v;

	wrl_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_num),
		.divisor(div_den),
		.busy(div_busy),
		.quotient(quo)
	);

	// sum carries a bias of RING_DEPTH*2^20, so the low bits of the quotient are the average
	assign avg_prod = AVG_PROD_W'(sum_q) * AVG_PROD_W'(AVG_RECIP);
	assign avg = avg_q;

	always_comb begin
		logic signed [POS_W:0] d;
		logic [POS_W:0] d_abs;
		any_dev = 1'b0;
		for (int i = 0; i < RING_DEPTH; i++) begin
			d = $signed({avg[POS_W-1], avg}) - $signed({ring_q[i][POS_W-1], ring_q[i]});
			d_abs = d[POS_W] ? (POS_W+1)'(-d) : (POS_W+1)'(d);
			if (d_abs > (POS_W+1)'(cfg.tolerance)) any_dev = 1'b1;
		end
	end
	assign avg_ok = ctl.use_avg & ~any_dev;

	assign step_x = SAT_W'(est_x_q) + SAT_W'(odo_x_q) - SAT_W'(odo_px_q);
	assign step_y = SAT_W'(est_y_q) + SAT_W'(odo_y_q) - SAT_W'(odo_py_q);

	// negative yaw: bits read as h+512, so h+360 is bits-152 modulo 512
	assign hdg_wrapped = heading_in[HDG_W-1] ? HDG_W'(heading_in) - 9'd152 : HDG_W'(heading_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_x_q <= RST_START_X;
			odo_x_q <= RST_START_X;
			odo_px_q <= RST_START_X;
			est_y_q <= RST_START_Y;
			odo_y_q <= RST_START_Y;
			odo_py_q <= RST_START_Y;
			left_q <= '0;
			right_q <= '0;
			ring_idx_q <= '0;
			ring_fill_q <= '0;
			heading_q <= RST_START_HDG;
			turn_q <= 1'b0;
			sum_idx_q <= '0;
		end else begin
			if (cfg_wr.x_we) begin
				est_x_q <= cfg_wr.start_x;
				odo_x_q <= cfg_wr.start_x;
				odo_px_q <= cfg_wr.start_x;
			end
			if (cfg_wr.y_we) begin
				est_y_q <= cfg_wr.start_y;
				odo_y_q <= cfg_wr.start_y;
				odo_py_q <= cfg_wr.start_y;
			end
			if (cfg_wr.hdg_we) begin
				heading_q <= (cfg_wr.start_heading >= 9'd360) ?
					cfg_wr.start_heading - 9'd360 : cfg_wr.start_heading;
			end
			if (ctl.accept) begin
				case (cmd)
					CMD_LEFT: if (!turn_q) left_q <= range_value;
					CMD_RIGHT: if (!turn_q) right_q <= range_value;
					CMD_ODOM: begin
						if (!turn_q) begin
							odo_px_q <= odo_x_q;
							odo_py_q <= odo_y_q;
							odo_x_q <= odom_x;
							odo_y_q <= odom_y;
						end
					end
					CMD_HEAD: heading_q <= hdg_wrapped;
					CMD_MOTOR: begin
						if (motor_turn) begin
							turn_q <= 1'b1;
						end else begin
							if (turn_q) begin
								ring_idx_q <= '0;
								ring_fill_q <= '0;
							end
							turn_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
			if (ctl.side_wr && span_ok) begin
				ring_idx_q <= (ring_idx_q == RING_IDX_W'(RING_DEPTH - 1)) ?
					'0 : ring_idx_q + 1'b1;
				if (ring_fill_q < RING_CNT_W'(RING_DEPTH)) ring_fill_q <= ring_fill_q + 1'b1;
			end
			if (ctl.sum_clr) begin
				sum_idx_q <= '0;
			end else if (ctl.sum_step) begin
				sum_idx_q <= sum_idx_q + 1'b1;
			end
			if (ctl.apply) begin
				if (facing_y) begin
					est_y_q <= sat_pos(step_y);
					odo_py_q <= odo_y_q;
					if (avg_ok) est_x_q <= avg;
				end else begin
					est_x_q <= sat_pos(step_x);
					odo_px_q <= odo_x_q;
					if (avg_ok) est_y_q <= avg;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.side_wr && span_ok) ring_q[ring_idx_q] <= entry;
		if (ctl.div_exp) prod_q <= lr_diff * $signed({1'b0, cos_v});
		if (ctl.sum_clr) begin
			sum_q <= AVG_BIAS;
		end else if (ctl.sum_step) begin
			sum_q <= sum_q + SUM_W'(ring_q[sum_idx_q]);
		end
		if (ctl.div_avg) avg_q <= avg_prod[AVG_SHIFT+POS_W-1:AVG_SHIFT];
	end

	assign st.turn = turn_q;
	assign st.full = (ring_fill_q == RING_CNT_W'(RING_DEPTH));
	assign st.div_busy = div_busy;
	assign st.sum_last = (sum_idx_q == RING_IDX_W'(RING_DEPTH - 1));

	assign est_x = est_x_q;
	assign est_y = est_y_q;
	assign heading = heading_q;
	assign turn = turn_q;

	`WRL_ASSERT(a_fill_max, ring_fill_q <= RING_CNT_W'(RING_DEPTH))
	`WRL_NEVER(a_idx_range, {1'b0, ring_idx_q} >= (RING_IDX_W+1)'(RING_DEPTH))
	`WRL_NEVER(a_hdg_range, heading_q >= 9'd360)

endmodule
`default_nettype wire

@@ dv/wrl_pose_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module wrl_pose_checker import wrl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic pready,
	input  logic in_valid,
	input  logic in_stall,
	input  logic [2:0] cmd,
	input  logic [LEN_W-1:0] range_value,
	input  logic signed [POS_W-1:0] odom_x,
	input  logic signed [POS_W-1:0] odom_y,
	input  logic signed [HDG_W-1:0] heading_in,
	input  logic motor_turn,
	input  logic out_valid,
	input  logic out_stall,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic [HDG_W-1:0] heading_out,
	input  logic is_turning,
	output int fail_count,
	output int pending
);

	typedef struct {
		int x;
		int y;
		int hdg;
		int turn;
	} pose_t;

	pose_t pose_expected[$];

	int cos_tab [0:45] = '{
		65536, 65526, 65496, 65446, 65376, 65287, 65177, 65048, 64898, 64729,
		64540, 64332, 64104, 63856, 63589, 63303, 62997, 62672, 62328, 61966,
		61584, 61183, 60764, 60326, 59870, 59396, 58903, 58393, 57865, 57319,
		56756, 56175, 55578, 54963, 54332, 53684, 53020, 52339, 51643, 50931,
		50203, 49461, 48703, 47930, 47143, 46341
	};

	longint cfg_course, cfg_robot, cfg_tol;
	int cfg_sx, cfg_sy, cfg_sh;
	int px, py, odo_now_x, odo_now_y, odo_last_x, odo_last_y;
	longint l_dist, r_dist;
	int lat_ring [0:RING_DEPTH-1];
	int ring_wr, ring_cnt, hdg, turning;

	function automatic longint fdiv(input longint n, input longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic int clip20(input longint v);
		if (v > 524287)
			return 524287;
		if (v < -524288)
			return -524288;
		return int'(v);
	endfunction

	function automatic bit along_y(input int h);
		return (h > 45 && h <= 135) || (h > 225 && h <= 315);
	endfunction

	function automatic int wrap_hdg(input int h);
		return (h >= 360) ? h - 360 : h;
	endfunction

	task automatic clear_ring();
		for (int i = 0; i < RING_DEPTH; i++)
			lat_ring[i] = 0;
		ring_wr = 0;
		ring_cnt = 0;
	endtask

	task automatic advance_pose();
		bit ok;
		longint avg, sum, d;
		ok = 0;
		avg = 0;
		if (turning)
			return;
		if (ring_cnt >= RING_DEPTH) begin
			sum = 0;
			for (int i = 0; i < RING_DEPTH; i++)
				sum += lat_ring[i];
			avg = fdiv(sum + RING_DEPTH / 2, RING_DEPTH);
			ok = 1;
			for (int i = 0; i < RING_DEPTH; i++) begin
				d = avg - lat_ring[i];
				if (d < 0)
					d = -d;
				if (d > cfg_tol)
					ok = 0;
			end
		end
		if (along_y(hdg)) begin
			py = clip20(longint'(py) + odo_now_y - odo_last_y);
			odo_last_y = odo_now_y;
			if (ok)
				px = int'(avg);
		end else begin
			px = clip20(longint'(px) + odo_now_x - odo_last_x);
			odo_last_x = odo_now_x;
			if (ok)
				py = int'(avg);
		end
	endtask

	task automatic add_lateral();
		int off;
		bit form_a;
		longint c, span, num, ent;
		if (hdg > 45 && hdg <= 135) begin
			off = 90 - hdg; form_a = 1;
		end else if (hdg > 135 && hdg <= 225) begin
			off = hdg - 180; form_a = 1;
		end else if (hdg > 225 && hdg <= 315) begin
			off = 270 - hdg; form_a = 0;
		end else begin
			off = (hdg > 315) ? hdg - 360 : hdg; form_a = 0;
		end
		if (off < 0)
			off = -off;
		if (off > 45)
			off = 45;
		c = cos_tab[off];
		span = (cfg_course * 65536 + c / 2) / c - cfg_robot - (l_dist + r_dist);
		if (span < 0)
			span = -span;
		if (span < 2 * cfg_tol) begin
			if (form_a)
				num = l_dist * c + cfg_course * 65536 - r_dist * c;
			else
				num = cfg_course * 65536 - l_dist * c + r_dist * c;
			ent = fdiv(num + 65536, 131072);
			lat_ring[ring_wr] = clip20(ent);
			ring_wr = (ring_wr + 1) % RING_DEPTH;
			if (ring_cnt < RING_DEPTH)
				ring_cnt++;
		end
		advance_pose();
	endtask

	task automatic push_pose();
		pose_t p;
		p.x = px;
		p.y = py;
		p.hdg = hdg;
		p.turn = turning;
		pose_expected.push_back(p);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pose_t e;
		int h;
		if (!arst_n) begin
			cfg_course = RST_COURSE;
			cfg_robot = RST_ROBOT_W;
			cfg_tol = RST_TOL;
			cfg_sx = RST_START_X;
			cfg_sy = RST_START_Y;
			cfg_sh = RST_START_HDG;
			px = cfg_sx; odo_now_x = cfg_sx; odo_last_x = cfg_sx;
			py = cfg_sy; odo_now_y = cfg_sy; odo_last_y = cfg_sy;
			l_dist = 0;
			r_dist = 0;
			clear_ring();
			hdg = wrap_hdg(cfg_sh);
			turning = 0;
			pose_expected.delete();
			fail_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pose_expected.size() == 0) begin
					$error("unexpected result transfer");
					fail_count++;
				end else begin
					e = pose_expected.pop_front();
					if (int'(pos_x) != e.x) begin
						$error("pos_x expected %0d actual %0d", e.x, pos_x);
						fail_count++;
					end
					if (int'(pos_y) != e.y) begin
						$error("pos_y expected %0d actual %0d", e.y, pos_y);
						fail_count++;
					end
					if (int'(heading_out) != e.hdg) begin
						$error("heading_out expected %0d actual %0d", e.hdg, heading_out);
						fail_count++;
					end
					if (int'(is_turning) != e.turn) begin
						$error("is_turning expected %0d actual %0d", e.turn, is_turning);
						fail_count++;
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_COURSE: cfg_course = pwdata[LEN_W-1:0];
					REG_ROBOT_W: cfg_robot = pwdata[TOL_W-1:0];
					REG_TOL: cfg_tol = pwdata[TOL_W-1:0];
					REG_START_X: begin
						cfg_sx = int'($signed(pwdata[POS_W-1:0]));
						px = cfg_sx; odo_now_x = cfg_sx; odo_last_x = cfg_sx;
					end
					REG_START_Y: begin
						cfg_sy = int'($signed(pwdata[POS_W-1:0]));
						py = cfg_sy; odo_now_y = cfg_sy; odo_last_y = cfg_sy;
					end
					REG_START_HDG: begin
						cfg_sh = pwdata[HDG_W-1:0];
						hdg = wrap_hdg(cfg_sh);
					end
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				case (cmd)
					CMD_LEFT, CMD_RIGHT: begin
						if (!turning) begin
							if (cmd == CMD_LEFT)
								l_dist = range_value;
							else
								r_dist = range_value;
							add_lateral();
							push_pose();
						end
					end
					CMD_ODOM: begin
						if (!turning) begin
							odo_last_x = odo_now_x;
							odo_last_y = odo_now_y;
							odo_now_x = odom_x;
							odo_now_y = odom_y;
							advance_pose();
							push_pose();
						end
					end
					CMD_HEAD: begin
						h = heading_in;
						if (h < 0)
							h += 360;
						hdg = h;
						advance_pose();
						push_pose();
					end
					CMD_MOTOR: begin
						if (motor_turn) begin
							turning = 1;
						end else begin
							if (turning)
								clear_ring();
							turning = 0;
						end
					end
					default: ;
				endcase
			end
		end
		pending = pose_expected.size();
	end

endmodule
`default_nettype wire

@@ dv/wall_range_odometry_localizer_top_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module wall_range_odometry_localizer_top_tb;
	import wrl_pkg::*;

	// idle cycles with no transfer anywhere before the run is abandoned
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE = 80;
	localparam int PHASE_ITEMS = 220;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic [2:0] cmd = CMD_MOTOR;
	logic [LEN_W-1:0] range_value = '0;
	logic signed [POS_W-1:0] odom_x = '0, odom_y = '0;
	logic signed [HDG_W-1:0] heading_in = '0;
	logic motor_turn = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [POS_W-1:0] pos_x, pos_y;
	logic [HDG_W-1:0] heading_out;
	logic is_turning;

	int fail_count, pending;
	int burst_left = 0;
	int idle_cnt = 0;
	logic hold_req = 0;

	// stimulus side view of the block, used only to shape well-formed ranges and odometry walks
	int cur_hdg = 90;
	int cur_course = 121242, cur_robot = 11653, cur_tol = 3277;
	logic signed [POS_W-1:0] odo_walk = '0;
	logic signed [POS_W-1:0] odo_walk_y = '0;

	always #5 clk = ~clk;

	wall_range_odometry_localizer_top u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .range_value(range_value), .odom_x(odom_x), .odom_y(odom_y),
		.heading_in(heading_in), .motor_turn(motor_turn),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_x(pos_x), .pos_y(pos_y), .heading_out(heading_out), .is_turning(is_turning)
	);

	wrl_pose_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .range_value(range_value), .odom_x(odom_x), .odom_y(odom_y),
		.heading_in(heading_in), .motor_turn(motor_turn),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_x(pos_x), .pos_y(pos_y), .heading_out(heading_out), .is_turning(is_turning),
		.fail_count(fail_count), .pending(pending)
	);

	// Watchdog: reset the count on any transfer, abandon the run if nothing moves.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(psel && penable && pready))
				idle_cnt <= 0;
			else
				idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Result side: pick a stall mode for a random stretch; on request hold off
	// for a long stretch so the block fills and stalls its input.
	initial begin
		int mode, left;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1;
				repeat (500) @(negedge clk);
				hold_req = 0;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(40, 300);
			end
			left--;
			case (mode)
				0: out_stall = 0;
				1: out_stall = ($urandom_range(0, 3) == 0);
				2: out_stall = ($urandom_range(0, 3) != 0);
				default: out_stall = ~out_stall;
			endcase
		end
	end

	// Offer one input transfer; called and returns at a falling edge.
	task automatic send(input logic [2:0] c, input int rv, input int ox, input int oy,
			input int hd, input logic mt);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			in_valid = 0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		cmd = c;
		range_value = rv[LEN_W-1:0];
		odom_x = ox[POS_W-1:0];
		odom_y = oy[POS_W-1:0];
		heading_in = hd[HDG_W-1:0];
		motor_turn = mt;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		burst_left--;
		if (c == CMD_HEAD)
			cur_hdg = (hd < 0) ? hd + 360 : hd;
	endtask

	task automatic reg_write(input logic [2:0] idx, input int val);
		psel = 1;
		penable = 0;
		pwrite = 1;
		paddr = PADDR_W'({idx, 2'b00});
		pwdata = val;
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	// Drain every expected result, let the block finish silent work, then write.
	task automatic set_course(input int course, input int robot, input int tol,
			input int sx, input int sy, input int sh);
		in_valid = 0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		reg_write(REG_COURSE, course);
		reg_write(REG_ROBOT_W, robot);
		reg_write(REG_TOL, tol);
		reg_write(REG_START_X, sx);
		reg_write(REG_START_Y, sy);
		reg_write(REG_START_HDG, sh);
		cur_course = course;
		cur_robot = robot;
		cur_tol = tol;
		cur_hdg = (sh >= 360) ? sh - 360 : sh;
		odo_walk = sx[POS_W-1:0];
		odo_walk_y = sy[POS_W-1:0];
	endtask

	// Wall span the block expects at the current heading, from real arithmetic.
	function automatic int wall_span();
		int off;
		real c;
		off = cur_hdg % 90;
		if (off > 45)
			off = 90 - off;
		c = $cos(off * 3.14159265358979 / 180.0);
		return int'(cur_course / c) - cur_robot;
	endfunction

	function automatic int clamp_len(input int v);
		if (v < 0)
			return 0;
		if (v > 524287)
			return 524287;
		return v;
	endfunction

	task automatic odo_step(input bit big);
		int dx, dy;
		dx = big ? $urandom_range(0, 200000) - 100000 : $urandom_range(0, 4000) - 2000;
		dy = big ? $urandom_range(0, 200000) - 100000 : $urandom_range(0, 4000) - 2000;
		odo_walk = odo_walk + POS_W'(dx);
		odo_walk_y = odo_walk_y + POS_W'(dy);
		send(CMD_ODOM, 0, odo_walk, odo_walk_y, 0, 0);
	endtask

	// Heading near a course axis, then ranges whose sum fits the span, mixed with small odometry steps.
	task automatic wall_run(inout int counted);
		int hd, span, base_l, jitter, n;
		hd = $urandom_range(0, 3) * 90 + $urandom_range(0, 24) - 12;
		if (hd > 180)
			hd -= 360;
		if (hd < -180)
			hd += 360;
		send(CMD_HEAD, 0, 0, 0, hd, 0);
		counted++;
		span = wall_span();
		base_l = (span > 0) ? $urandom_range(0, span) : 0;
		jitter = (cur_tol / 4) + 1;
		n = $urandom_range(4, 14);
		repeat (n) begin
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 1))
					send(CMD_LEFT, clamp_len(base_l + $urandom_range(0, 2 * jitter) - jitter),
						0, 0, 0, 0);
				else
					send(CMD_RIGHT, clamp_len(span - base_l + $urandom_range(0, 2 * jitter)
						- jitter), 0, 0, 0, 0);
			end else begin
				odo_step(0);
			end
			counted++;
		end
	endtask

	task automatic turn_run(inout int counted);
		send(CMD_MOTOR, 0, 0, 0, 0, 1);
		repeat ($urandom_range(1, 5)) begin
			case ($urandom_range(0, 3))
				0: send(CMD_LEFT, $urandom_range(0, 524287), 0, 0, 0, 0);
				1: send(CMD_RIGHT, $urandom_range(0, 524287), 0, 0, 0, 0);
				2: odo_step(1);
				default: send(CMD_HEAD, 0, 0, 0, $urandom_range(0, 360) - 180, 0);
			endcase
			counted++;
		end
		send(CMD_MOTOR, 0, 0, 0, 0, 0);
		counted += 2;
	endtask

	task automatic random_phase(input int target, input bit squeeze);
		int counted, c;
		bit held;
		counted = 0;
		held = 0;
		while (counted < target) begin
			if (squeeze && !held && counted > target / 2) begin
				hold_req = 1;
				held = 1;
			end
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: wall_run(counted);
				11, 12, 13: begin
					odo_step($urandom_range(0, 3) == 0);
					counted++;
				end
				14, 15: turn_run(counted);
				default: begin
					c = $urandom_range(0, 7);
					send(c[2:0], $urandom_range(0, 524287),
						$urandom_range(0, 1048575) - 524288,
						$urandom_range(0, 1048575) - 524288,
						$urandom_range(0, 360) - 180, $urandom_range(0, 1));
					if (c < 5)
						counted++;
				end
			endcase
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: sector boundaries, field extremes, turn handling, unused codes
		send(CMD_LEFT, 0, 0, 0, 0, 0);
		send(CMD_RIGHT, 524287, 0, 0, 0, 0);
		send(CMD_LEFT, 60000, 0, 0, 0, 0);
		send(CMD_RIGHT, 49589, 0, 0, 0, 0);
		send(CMD_ODOM, 0, 524287, -524288, 0, 0);
		send(CMD_ODOM, 0, -524288, 524287, 0, 0);
		send(CMD_HEAD, 0, 0, 0, 45, 0);
		send(CMD_HEAD, 0, 0, 0, 46, 0);
		send(CMD_HEAD, 0, 0, 0, 135, 0);
		send(CMD_HEAD, 0, 0, 0, 136, 0);
		send(CMD_HEAD, 0, 0, 0, -135, 0);
		send(CMD_HEAD, 0, 0, 0, -134, 0);
		send(CMD_HEAD, 0, 0, 0, -45, 0);
		send(CMD_HEAD, 0, 0, 0, -44, 0);
		send(CMD_HEAD, 0, 0, 0, -180, 0);
		send(CMD_HEAD, 0, 0, 0, 180, 0);
		send(CMD_MOTOR, 0, 0, 0, 0, 0);
		send(CMD_MOTOR, 0, 0, 0, 0, 1);
		send(CMD_LEFT, 1000, 0, 0, 0, 0);
		send(CMD_ODOM, 0, 5, 5, 0, 0);
		send(CMD_HEAD, 0, 0, 0, 0, 0);
		send(CMD_MOTOR, 0, 0, 0, 0, 0);
		send(3'd5, 0, 0, 0, 0, 0);
		send(3'd6, 0, 0, 0, 0, 1);
		send(3'd7, 524287, 524287, 524287, 180, 1);

		random_phase(PHASE_ITEMS, 1);
		set_course(121242, 11653, 3277, 68813, 9830, 90);
		random_phase(PHASE_ITEMS, 0);
		set_course(524287, 65535, 65535, 524287, 524287, 359);
		random_phase(PHASE_ITEMS / 2, 0);
		set_course(0, 0, 0, -524288, -524288, 0);
		random_phase(PHASE_ITEMS / 2, 0);
		set_course(150000, 9000, 6000, -1000, 2000, 370);
		random_phase(PHASE_ITEMS, 0);
		repeat (3) begin
			set_course($urandom_range(60000, 300000), $urandom_range(0, 20000),
				$urandom_range(500, 8000), $urandom_range(0, 1048575) - 524288,
				$urandom_range(0, 1048575) - 524288, $urandom_range(0, 359));
			random_phase(PHASE_ITEMS, 1);
		end

		// drain and let the block settle before the verdict
		in_valid = 0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire
